### rtl/sfla_pkg.sv
package sfla_pkg;

    localparam int ADDR_W  = 32;
    localparam int SIZE_W  = 13;
    // Effective object size after raising and rounding; one bit more than the register.
    localparam int ESIZE_W = SIZE_W + 1;
    localparam int MIN_OBJ_BYTES = 8;
    localparam logic [SIZE_W-1:0] OBJECT_SIZE_RESET = SIZE_W'(8);

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_OOM      = 3'd1,
        STAT_NOFIT    = 3'd2,
        STAT_NULLFREE = 3'd3,
        STAT_OVERFLOW = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CARVE,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic              cmd;
        logic [ADDR_W-1:0] object_address;
        logic [ADDR_W-1:0] fresh_frame;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] granted_address;
        logic              frame_consumed;
        status_t           status;
    } rsp_t;

endpackage

### rtl/sfla_ram.sv
module sfla_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/sfla_out_reg.sv
module sfla_out_reg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  sfla_pkg::rsp_t load_data,
    output logic          slot_free,
    output logic          valid,
    input  logic          stall,
    output sfla_pkg::rsp_t data
);

    logic           valid_reg;
    logic           valid_next;
    sfla_pkg::rsp_t data_reg;

    assign slot_free = !valid_reg || !stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

### rtl/sfla_ctrl.sv
module sfla_ctrl #(
    parameter int PAGE_BYTES   = 4096,
    parameter int HEADER_BYTES = 16,
    parameter int ALIGN_BYTES  = 8,
    parameter int STACK_DEPTH  = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [sfla_pkg::SIZE_W-1:0]     cfg_wr_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  sfla_pkg::req_t                  in_data,
    output logic                            mem_we,
    output logic [$clog2(STACK_DEPTH)-1:0]  mem_waddr,
    output logic [sfla_pkg::ADDR_W-1:0]     mem_wdata,
    output logic                            mem_re,
    output logic [$clog2(STACK_DEPTH)-1:0]  mem_raddr,
    input  logic [sfla_pkg::ADDR_W-1:0]     mem_rdata,
    input  logic                            out_slot_free,
    output logic                            out_load,
    output sfla_pkg::rsp_t                  out_load_data
);

    localparam int IDX_W   = $clog2(STACK_DEPTH);
    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int HDR_OFF = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    localparam int OFF_W   = $clog2(PAGE_BYTES + (1 << sfla_pkg::ESIZE_W) + 1);
    localparam logic [sfla_pkg::ESIZE_W-1:0] ALIGN_MASK =
        sfla_pkg::ESIZE_W'(ALIGN_BYTES - 1);

    sfla_pkg::state_t                 state_reg, state_next;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic [sfla_pkg::SIZE_W-1:0]      object_size_reg;
    sfla_pkg::rsp_t                   res_reg, res_next;
    logic [sfla_pkg::ADDR_W-1:0]      carve_addr_reg, carve_addr_next;
    logic [sfla_pkg::ADDR_W-1:0]      last_reg, last_next;
    logic [OFF_W-1:0]                 carve_end_reg, carve_end_next;
    logic [sfla_pkg::ESIZE_W-1:0]     size_raised;
    logic [sfla_pkg::ESIZE_W-1:0]     size_eff;
    logic                             stack_full;
    logic                             accept;

    // ALIGN_BYTES is a power of two: round up by add and mask.
    always_comb
    begin
        if (object_size_reg < sfla_pkg::SIZE_W'(sfla_pkg::MIN_OBJ_BYTES))
        begin
            size_raised = sfla_pkg::ESIZE_W'(sfla_pkg::MIN_OBJ_BYTES);
        end
        else
        begin
            size_raised = sfla_pkg::ESIZE_W'(object_size_reg);
        end
        size_eff = (size_raised + ALIGN_MASK) & ~ALIGN_MASK;
    end

    assign stack_full = (count_reg == CNT_W'(STACK_DEPTH));
    assign in_stall   = (state_reg != sfla_pkg::S_IDLE);
    assign accept     = in_valid && (state_reg == sfla_pkg::S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        res_next        = res_reg;
        carve_addr_next = carve_addr_reg;
        carve_end_next  = carve_end_reg;
        last_next       = last_reg;
        mem_we          = 1'b0;
        mem_waddr       = count_reg[IDX_W-1:0];
        mem_wdata       = in_data.object_address;
        mem_re          = 1'b0;
        mem_raddr       = IDX_W'(count_reg - CNT_W'(1));
        out_load        = 1'b0;
        out_load_data   = res_reg;

        unique case (state_reg)
            sfla_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    res_next.granted_address = '0;
                    res_next.frame_consumed  = 1'b0;
                    res_next.status          = sfla_pkg::STAT_OK;
                    state_next               = sfla_pkg::S_EMIT;
                    if (in_data.cmd == sfla_pkg::CMD_FREE)
                    begin
                        if (in_data.object_address == '0)
                        begin
                            res_next.status = sfla_pkg::STAT_NULLFREE;
                        end
                        else if (stack_full)
                        begin
                            res_next.status = sfla_pkg::STAT_OVERFLOW;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else if (count_reg != '0)
                    begin
                        mem_re     = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                        state_next = sfla_pkg::S_READ;
                    end
                    else if (in_data.fresh_frame == '0)
                    begin
                        res_next.status = sfla_pkg::STAT_OOM;
                    end
                    else if (OFF_W'(HDR_OFF) + OFF_W'(size_eff) > OFF_W'(PAGE_BYTES))
                    begin
                        res_next.status = sfla_pkg::STAT_NOFIT;
                    end
                    else
                    begin
                        carve_addr_next = in_data.fresh_frame + sfla_pkg::ADDR_W'(HDR_OFF);
                        carve_end_next  = OFF_W'(HDR_OFF) + OFF_W'(size_eff);
                        state_next      = sfla_pkg::S_CARVE;
                    end
                end
            end

            sfla_pkg::S_READ:
            begin
                res_next.granted_address = mem_rdata;
                res_next.frame_consumed  = 1'b0;
                res_next.status          = sfla_pkg::STAT_OK;
                if (out_slot_free)
                begin
                    out_load      = 1'b1;
                    out_load_data = res_next;
                    state_next    = sfla_pkg::S_IDLE;
                end
                else
                begin
                    state_next = sfla_pkg::S_EMIT;
                end
            end

            sfla_pkg::S_CARVE:
            begin
                res_next.frame_consumed = 1'b1;
                if (stack_full)
                begin
                    // Drop the rest of the page; grant the last object pushed.
                    count_next               = count_reg - CNT_W'(1);
                    res_next.granted_address = last_reg;
                    res_next.status          = sfla_pkg::STAT_OVERFLOW;
                    state_next               = sfla_pkg::S_EMIT;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_wdata = carve_addr_reg;
                    last_next = carve_addr_reg;
                    if (carve_end_reg + OFF_W'(size_eff) > OFF_W'(PAGE_BYTES))
                    begin
                        // Final push and the pop cancel in the count.
                        res_next.granted_address = carve_addr_reg;
                        res_next.status          = sfla_pkg::STAT_OK;
                        state_next               = sfla_pkg::S_EMIT;
                    end
                    else
                    begin
                        count_next      = count_reg + CNT_W'(1);
                        carve_addr_next = carve_addr_reg + sfla_pkg::ADDR_W'(size_eff);
                        carve_end_next  = carve_end_reg + OFF_W'(size_eff);
                    end
                end
            end

            sfla_pkg::S_EMIT:
            begin
                if (out_slot_free)
                begin
                    out_load   = 1'b1;
                    state_next = sfla_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = sfla_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= sfla_pkg::S_IDLE;
            count_reg       <= '0;
            object_size_reg <= sfla_pkg::OBJECT_SIZE_RESET;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_wr_en)
            begin
                object_size_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg        <= res_next;
        carve_addr_reg <= carve_addr_next;
        carve_end_reg  <= carve_end_next;
        last_reg       <= last_next;
    end

endmodule

### rtl/slab_free_list_allocator_unit.sv
// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_stall   sfla_pkg::req_t (cmd, object_address, fresh_frame)
// out       output     out_valid/out_stall sfla_pkg::rsp_t (granted_address, frame_consumed,
//                                          status)
// cfg       input      cfg_wr_en           cfg_wr_data = object_size
//
// A free, a pop or an alloc that fails is accepted in S_IDLE, which writes the stack memory
// or starts its registered read; S_READ or S_EMIT then loads the result once the output frees.
// An alloc on an empty stack carves the page at one push per cycle into the stack memory
// in S_CARVE, then S_EMIT loads the result; a full stack drops the rest of the page.
// Reset clears the fill count, state, object size and output valid; the stack memory needs no clearing pass.
// The output register lets the next request enter while a result waits under out_stall;
// a result that cannot leave holds the controller until the output register frees.
module slab_free_list_allocator_unit #(
    parameter int PAGE_BYTES   = 4096,
    parameter int HEADER_BYTES = 16,
    parameter int ALIGN_BYTES  = 8,
    parameter int STACK_DEPTH  = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [sfla_pkg::SIZE_W-1:0] cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  sfla_pkg::req_t              in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output sfla_pkg::rsp_t              out_data
);

    localparam int IDX_W = $clog2(STACK_DEPTH);

    logic                        mem_we;
    logic [IDX_W-1:0]            mem_waddr;
    logic [sfla_pkg::ADDR_W-1:0] mem_wdata;
    logic                        mem_re;
    logic [IDX_W-1:0]            mem_raddr;
    logic [sfla_pkg::ADDR_W-1:0] mem_rdata;
    logic                        out_slot_free;
    logic                        out_load;
    sfla_pkg::rsp_t              out_load_data;

    sfla_ctrl #(
        .PAGE_BYTES   (PAGE_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .ALIGN_BYTES  (ALIGN_BYTES),
        .STACK_DEPTH  (STACK_DEPTH)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_data       (in_data),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_re        (mem_re),
        .mem_raddr     (mem_raddr),
        .mem_rdata     (mem_rdata),
        .out_slot_free (out_slot_free),
        .out_load      (out_load),
        .out_load_data (out_load_data)
    );

    sfla_ram #(
        .WIDTH (sfla_pkg::ADDR_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    sfla_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .load_data (out_load_data),
        .slot_free (out_slot_free),
        .valid     (out_valid),
        .stall     (out_stall),
        .data      (out_data)
    );

endmodule

### rtl/sfla_checker.sv
module sfla_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_stall,
    input logic           out_valid,
    input logic           out_stall,
    input sfla_pkg::rsp_t out_data
);

    // Hold a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed or dropped");

    // Each accepted request leaves the block busy, so no request is accepted right behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted back to back");

    // A carved frame only ends in ok or overflow.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.frame_consumed |->
            out_data.status == sfla_pkg::STAT_OK ||
            out_data.status == sfla_pkg::STAT_OVERFLOW)
        else $error("frame consumed with a failing status");

    // Failing requests grant nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == sfla_pkg::STAT_OOM ||
                      out_data.status == sfla_pkg::STAT_NOFIT ||
                      out_data.status == sfla_pkg::STAT_NULLFREE) |->
            out_data.granted_address == '0 && !out_data.frame_consumed)
        else $error("failing request granted an address");

endmodule

bind slab_free_list_allocator_unit sfla_checker u_sfla_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int PAGE_BYTES   = 4096;
    localparam int HEADER_BYTES = 16;
    localparam int ALIGN_BYTES  = 8;
    localparam int STACK_DEPTH  = 1024;

    typedef enum {
        QUIET,
        SENDER_GAPS,
        RECEIVER_STALLS,
        BOTH_IDLE
    } idle_mode_t;

    typedef struct packed {
        logic [sfla_pkg::SIZE_W-1:0] size;
        sfla_pkg::req_t              req;
        logic                        typed;
        sfla_pkg::rsp_t              want;
    } stim_row_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_wr_en = 1'b0;
    logic [sfla_pkg::SIZE_W-1:0] cfg_wr_data = '0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    sfla_pkg::req_t              in_data = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    sfla_pkg::rsp_t              out_data;

    // Allocator state as the block should hold it
    logic [sfla_pkg::ADDR_W-1:0] free_addrs [0:STACK_DEPTH-1];
    int unsigned                 free_count = 0;
    logic [sfla_pkg::SIZE_W-1:0] object_size_q = sfla_pkg::OBJECT_SIZE_RESET;

    sfla_pkg::rsp_t              answers_due [$];
    logic [sfla_pkg::ADDR_W-1:0] live_objects [$];
    stim_row_t                   directed_rows [$];
    int                          errors = 0;
    int                          send_idle_pct = 0;
    int                          stall_pct = 0;

    slab_free_list_allocator_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #50_000_000;
        $display("testbench: errors");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        errors++;
    endtask

    function automatic sfla_pkg::rsp_t allocator_answer(input sfla_pkg::req_t r);
        sfla_pkg::rsp_t a;
        int unsigned    obj_bytes;
        int unsigned    offset;
        bit             full;
        a = '0;
        a.status = sfla_pkg::STAT_OK;
        if (r.cmd == sfla_pkg::CMD_FREE)
        begin
            if (r.object_address == '0)
                a.status = sfla_pkg::STAT_NULLFREE;
            else if (free_count >= STACK_DEPTH)
                a.status = sfla_pkg::STAT_OVERFLOW;
            else
            begin
                free_addrs[free_count] = r.object_address;
                free_count++;
            end
        end
        else if (free_count != 0)
        begin
            free_count--;
            a.granted_address = free_addrs[free_count];
        end
        else if (r.fresh_frame == '0)
            a.status = sfla_pkg::STAT_OOM;
        else
        begin
            obj_bytes = (object_size_q < sfla_pkg::MIN_OBJ_BYTES) ?
                        sfla_pkg::MIN_OBJ_BYTES : object_size_q;
            obj_bytes = (obj_bytes + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
            offset = (HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
            if (offset + obj_bytes > PAGE_BYTES)
                a.status = sfla_pkg::STAT_NOFIT;
            else
            begin
                // carve upward; drop the rest of the page once the stack is full
                full = 1'b0;
                while (!full && offset + obj_bytes <= PAGE_BYTES)
                begin
                    if (free_count >= STACK_DEPTH)
                    begin
                        full = 1'b1;
                        a.status = sfla_pkg::STAT_OVERFLOW;
                    end
                    else
                    begin
                        free_addrs[free_count] = r.fresh_frame + sfla_pkg::ADDR_W'(offset);
                        free_count++;
                        offset += obj_bytes;
                    end
                end
                free_count--;
                a.granted_address = free_addrs[free_count];
                a.frame_consumed = 1'b1;
            end
        end
        return a;
    endfunction

    task automatic check_answer(input sfla_pkg::rsp_t got);
        sfla_pkg::rsp_t want;
        if (answers_due.size() == 0)
        begin
            report_mismatch($sformatf("answer with nothing pending, addr %h",
                                      got.granted_address));
            return;
        end
        want = answers_due.pop_front();
        if (got.granted_address !== want.granted_address)
            report_mismatch($sformatf("granted_address %h, want %h",
                                      got.granted_address, want.granted_address));
        if (got.frame_consumed !== want.frame_consumed)
            report_mismatch($sformatf("frame_consumed %b, want %b",
                                      got.frame_consumed, want.frame_consumed));
        if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            check_answer(out_data);
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic wait_for_answers();
        in_valid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_object_size(input logic [sfla_pkg::SIZE_W-1:0] size);
        wait_for_answers();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= size;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        object_size_q = size;
    endtask

    task automatic set_idle_mode(input idle_mode_t mode);
        send_idle_pct = (mode == SENDER_GAPS) ? 79 : (mode == BOTH_IDLE) ? 34 : 0;
        stall_pct     = (mode == RECEIVER_STALLS) ? 79 : (mode == BOTH_IDLE) ? 34 : 0;
    endtask

    // Drive one request, hold it until accepted, then queue what it must answer.
    task automatic send_request(input sfla_pkg::req_t r, input logic typed,
                                input sfla_pkg::rsp_t want, output sfla_pkg::rsp_t answer);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do
            @(posedge clk);
        while (in_stall);
        answer = allocator_answer(r);
        if (answer.granted_address != '0 && live_objects.size() < 256)
            live_objects.push_back(answer.granted_address);
        answers_due.push_back(typed ? want : answer);
    endtask

    function automatic sfla_pkg::req_t random_request(input bit is_alloc);
        sfla_pkg::req_t r;
        int unsigned    pick;
        int unsigned    idx;
        r.cmd = is_alloc ? sfla_pkg::CMD_ALLOC : sfla_pkg::CMD_FREE;
        r.object_address = $urandom();
        r.fresh_frame = $urandom();
        pick = $urandom_range(15);
        if (is_alloc)
        begin
            if (pick == 0)
                r.fresh_frame = '0;
            else if (pick < 12)
                r.fresh_frame[11:0] = '0;
        end
        else if (pick == 0)
            r.object_address = '0;
        else if (pick < 9 && live_objects.size() != 0)
        begin
            // hand back an object that was granted earlier
            idx = $urandom_range(live_objects.size() - 1);
            r.object_address = live_objects[idx];
            live_objects.delete(idx);
        end
        return r;
    endfunction

    task automatic run_phase(input int size, input int items,
                             input int alloc_pct, input bit drain_first, input bit fill,
                             input idle_mode_t mode);
        sfla_pkg::req_t r;
        sfla_pkg::rsp_t got;
        int             sent;
        int             overflows;
        set_object_size(sfla_pkg::SIZE_W'(size));
        set_idle_mode(mode);
        if (drain_first)
        begin
            while (free_count != 0)
                send_request(random_request(1'b1), 1'b0, '0, got);
            // start from one freshly carved page
            r = random_request(1'b1);
            r.fresh_frame = 32'h0004_0000;
            send_request(r, 1'b0, '0, got);
        end
        sent = 0;
        overflows = 0;
        while (fill ? (overflows < 10 && sent < 800) : (sent < items))
        begin
            if ($urandom_range(59) == 0)
                wait_for_answers();
            r = random_request($urandom_range(99) < alloc_pct);
            send_request(r, 1'b0, '0, got);
            if (got.status == sfla_pkg::STAT_OVERFLOW)
                overflows++;
            sent++;
        end
    endtask

    task automatic add_row(input logic [sfla_pkg::SIZE_W-1:0] size, input logic cmd,
                           input logic [sfla_pkg::ADDR_W-1:0] obj,
                           input logic [sfla_pkg::ADDR_W-1:0] frame,
                           input logic typed, input logic [sfla_pkg::ADDR_W-1:0] addr,
                           input logic used, input sfla_pkg::status_t st);
        stim_row_t row;
        row.size = size;
        row.req.cmd = cmd;
        row.req.object_address = obj;
        row.req.fresh_frame = frame;
        row.typed = typed;
        row.want.granted_address = addr;
        row.want.frame_consumed = used;
        row.want.status = st;
        directed_rows.push_back(row);
    endtask

    initial
    begin
        sfla_pkg::rsp_t got;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(13'd8191, sfla_pkg::CMD_ALLOC, 32'h0, 32'h0000_1000,
                1'b1, 32'h0, 1'b0, sfla_pkg::STAT_NOFIT);
        add_row(13'd4081, sfla_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 32'h0000_1000,
                1'b1, 32'h0, 1'b0, sfla_pkg::STAT_NOFIT);
        add_row(13'd4080, sfla_pkg::CMD_ALLOC, 32'h0, 32'hFFFF_F000,
                1'b1, 32'hFFFF_F010, 1'b1, sfla_pkg::STAT_OK);
        add_row(13'd4080, sfla_pkg::CMD_ALLOC, 32'h0, 32'h0,
                1'b1, 32'h0, 1'b0, sfla_pkg::STAT_OOM);
        add_row(13'd4080, sfla_pkg::CMD_FREE, 32'h0, 32'hFFFF_FFFF,
                1'b1, 32'h0, 1'b0, sfla_pkg::STAT_NULLFREE);
        add_row(13'd4080, sfla_pkg::CMD_FREE, 32'hFFFF_FFFF, 32'h0,
                1'b1, 32'h0, 1'b0, sfla_pkg::STAT_OK);
        add_row(13'd4080, sfla_pkg::CMD_ALLOC, 32'h0, 32'h0,
                1'b0, 32'h0, 1'b0, sfla_pkg::STAT_OK);
        add_row(13'd4096, sfla_pkg::CMD_ALLOC, 32'h0, 32'h0000_2000,
                1'b1, 32'h0, 1'b0, sfla_pkg::STAT_NOFIT);
        add_row(13'd2001, sfla_pkg::CMD_ALLOC, 32'h0, 32'h0000_2000,
                1'b1, 32'h0000_27E8, 1'b1, sfla_pkg::STAT_OK);
        add_row(13'd2001, sfla_pkg::CMD_FREE, 32'h8000_0000, 32'h0,
                1'b0, 32'h0, 1'b0, sfla_pkg::STAT_OK);
        add_row(13'd2001, sfla_pkg::CMD_FREE, 32'h0000_0001, 32'h0,
                1'b0, 32'h0, 1'b0, sfla_pkg::STAT_OK);
        add_row(13'd2001, sfla_pkg::CMD_ALLOC, 32'h0, 32'h0,
                1'b0, 32'h0, 1'b0, sfla_pkg::STAT_OK);
        add_row(13'd2001, sfla_pkg::CMD_ALLOC, 32'h0, 32'h0,
                1'b0, 32'h0, 1'b0, sfla_pkg::STAT_OK);
        add_row(13'd2001, sfla_pkg::CMD_ALLOC, 32'h0, 32'h0,
                1'b0, 32'h0, 1'b0, sfla_pkg::STAT_OK);
        // frame at the top of the address space: carved addresses wrap
        add_row(13'd2001, sfla_pkg::CMD_ALLOC, 32'h0, 32'hFFFF_FFF8,
                1'b1, 32'h0000_07E0, 1'b1, sfla_pkg::STAT_OK);
        add_row(13'd2001, sfla_pkg::CMD_ALLOC, 32'h0, 32'h0,
                1'b0, 32'h0, 1'b0, sfla_pkg::STAT_OK);
        add_row(13'd2001, sfla_pkg::CMD_ALLOC, 32'h0, 32'h0,
                1'b1, 32'h0, 1'b0, sfla_pkg::STAT_OOM);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].size != object_size_q)
                set_object_size(directed_rows[i].size);
            send_request(directed_rows[i].req, directed_rows[i].typed,
                         directed_rows[i].want, got);
        end

        run_phase(1000, 40, 60, 1'b0, 1'b0, QUIET);
        run_phase(4096, 20, 70, 1'b0, 1'b0, SENDER_GAPS);
        run_phase(int'($urandom_range(24, 600)), 30, 60, 1'b0, 1'b0, RECEIVER_STALLS);
        // carve a page of minimum-size objects, then free until the stack overflows
        run_phase(0, 0, 0, 1'b1, 1'b1, BOTH_IDLE);
        run_phase(1, 20, 55, 1'b0, 1'b0, SENDER_GAPS);

        wait_for_answers();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
